@@ src/fractal_gradient_noise_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FRACTAL_GRADIENT_NOISE_UNIT_DEFINES_SVH
`define FRACTAL_GRADIENT_NOISE_UNIT_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define FGN_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fgn implication violated");

// Condition that must never be seen outside reset.
`define FGN_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fgn forbidden condition seen");

`endif

@@ src/fgn_pkg.sv @@
package fgn_pkg;

    localparam int COORD_W   = 32;
    localparam int P_W       = 40;
    localparam int CELL_W    = 8;
    localparam int BASE_W    = 24;
    localparam int AMP_W     = 17;
    localparam int OCT_W     = 5;
    localparam int OUT_W     = 21;
    localparam int HASH_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;

    // Dimension codes; every other code evaluates in three dimensions
    localparam logic [1:0] DIM_1D = 2'd1;
    localparam logic [1:0] DIM_2D = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X       = 3'd0,
        REG_OFFSET_Y       = 3'd1,
        REG_OFFSET_Z       = 3'd2,
        REG_BASE_FREQUENCY = 3'd3,
        REG_PERSISTENCE    = 3'd4,
        REG_OCTAVE_COUNT   = 3'd5,
        REG_DIMENSION_MODE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [AMP_W-1:0] pers;
        logic [OCT_W-1:0] octs;
    } fgn_cfg_t;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic [7:0] perm(input logic [7:0] idx);
        return PERM[idx];
    endfunction

endpackage

@@ src/fgn_front.sv @@
module fgn_front (
    input  logic                          clk,
    input  logic                          accept,
    input  logic [fgn_pkg::COORD_W-1:0]   coord_x,
    input  logic [fgn_pkg::COORD_W-1:0]   coord_y,
    input  logic [fgn_pkg::COORD_W-1:0]   coord_z,
    input  logic [fgn_pkg::COORD_W-1:0]   offset_x,
    input  logic [fgn_pkg::COORD_W-1:0]   offset_y,
    input  logic [fgn_pkg::COORD_W-1:0]   offset_z,
    input  logic [fgn_pkg::BASE_W-1:0]    base_frequency,
    output logic [fgn_pkg::P_W-1:0]       px,
    output logic [fgn_pkg::P_W-1:0]       py,
    output logic [fgn_pkg::P_W-1:0]       pz
);
    import fgn_pkg::*;

    localparam int PROD_W = COORD_W + BASE_W;

    logic [COORD_W-1:0] pos_reg [3];
    logic [COORD_W-1:0] pos_next [3];
    logic [P_W-1:0]     scaled_reg [3];
    logic [P_W-1:0]     scaled_next [3];
    logic [PROD_W-1:0]  prod [3];

    // Translate the point, wrapping at the coordinate width
    always_comb
    begin
        pos_next[0] = coord_x + offset_x;
        pos_next[1] = coord_y + offset_y;
        pos_next[2] = coord_z + offset_z;
    end

    // Scale by the base frequency; keep the low bits, correcting for the sign
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            prod[d] = PROD_W'(pos_reg[d]) * PROD_W'(base_frequency);
            scaled_next[d] = prod[d][P_W-1:0]
                - (pos_reg[d][COORD_W-1] ? {base_frequency[7:0], 32'd0} : P_W'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= pos_next;
        end
        scaled_reg <= scaled_next;
    end

    assign px = scaled_reg[0];
    assign py = scaled_reg[1];
    assign pz = scaled_reg[2];

endmodule

@@ src/fgn_cell.sv @@
module fgn_cell #(
    parameter int IDX       = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fgn_pkg::fgn_cfg_t                 cfg,
    input  logic [fgn_pkg::P_W-1:0]           px_in,
    input  logic [fgn_pkg::P_W-1:0]           py_in,
    input  logic [fgn_pkg::P_W-1:0]           pz_in,
    input  logic [fgn_pkg::AMP_W-1:0]         amp_in,
    input  logic signed [FRAC_BITS+28:0]      sum_in,
    output logic [fgn_pkg::P_W-1:0]           px_out,
    output logic [fgn_pkg::P_W-1:0]           py_out,
    output logic [fgn_pkg::P_W-1:0]           pz_out,
    output logic [fgn_pkg::AMP_W-1:0]         amp_out,
    output logic signed [FRAC_BITS+28:0]      sum_out
);
    import fgn_pkg::*;

    localparam int W      = FRAC_BITS + 6;
    localparam int SUM_W  = FRAC_BITS + 29;
    localparam int PA_W   = W + AMP_W + 1;

    typedef logic signed [W-1:0]   fx_t;
    typedef logic signed [2*W-1:0] wide_t;

    localparam fx_t ONE = fx_t'(1) <<< FRAC_BITS;

    function automatic fx_t fmul(input fx_t a, input fx_t b);
        wide_t p;
        p = a * b;
        return fx_t'(p >>> FRAC_BITS);
    endfunction

    function automatic fx_t grad(input logic [HASH_W-1:0] h, input fx_t x,
                                 input fx_t y, input fx_t z);
        fx_t u;
        fx_t v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    logic is_1d;
    logic is_2d;
    logic active;

    // Cell stage
    logic [CELL_W-1:0] cell_c0 [3];
    fx_t               t_c0 [3];
    fx_t               poly_c0 [3];
    logic [CELL_W-1:0] cell_s1_reg [3];
    fx_t               t_s1_reg [3];
    fx_t               poly_s1_reg [3];
    logic [7:0]        hi0_s1_reg;
    logic [7:0]        hi1_s1_reg;

    // Second hash level
    logic [8:0]        a_c1;
    logic [8:0]        b_c1;
    fx_t               t_s2_reg [3];
    fx_t               q_s2_reg [3];
    logic [7:0]        hi0_s2_reg;
    logic [7:0]        hi1_s2_reg;
    logic [HASH_W-1:0] a_s2_reg;
    logic [HASH_W-1:0] b_s2_reg;
    logic [7:0]        aa_s2_reg;
    logic [7:0]        ab_s2_reg;
    logic [7:0]        ba_s2_reg;
    logic [7:0]        bb_s2_reg;

    // Corner hashes
    logic [7:0]        look_c2 [8];
    logic [HASH_W-1:0] h_c2 [8];
    logic [HASH_W-1:0] h_s3_reg [8];
    fx_t               t_s3_reg [3];
    fx_t               r_s3_reg [3];

    // Gradients
    fx_t               fade_s4_reg [3];
    fx_t               g_s4_reg [8];
    fx_t               g_c3 [8];
    fx_t               yy_c3;
    fx_t               zz_c3;

    // Interpolation levels
    wide_t             p1_s5_reg [4];
    fx_t               b1_s5_reg [4];
    fx_t               fv_s5_reg;
    fx_t               fw_s5_reg;
    fx_t               l_s6_reg [4];
    fx_t               fv_s6_reg;
    fx_t               fw_s6_reg;
    wide_t             p2_s7_reg [2];
    fx_t               b2_s7_reg [2];
    fx_t               fw_s7_reg;
    fx_t               l0_s7_reg;
    fx_t               m_s8_reg [2];
    fx_t               fw_s8_reg;
    fx_t               l0_s8_reg;
    wide_t             p3_s9_reg;
    fx_t               m0_s9_reg;
    fx_t               l0_s9_reg;
    fx_t               n_next;
    fx_t               n_s10_reg;
    logic signed [PA_W-1:0] pa_s11_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    logic [P_W-1:0]    px_reg;
    logic [P_W-1:0]    py_reg;
    logic [P_W-1:0]    pz_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [AMP_W-1:0]  amp_next;
    logic [2*AMP_W-1:0] amp_prod;

    assign is_1d  = (cfg.mode == DIM_1D);
    assign is_2d  = (cfg.mode == DIM_2D);
    assign active = (OCT_W'(IDX) < cfg.octs);

    // Split into lattice cell and fraction; first fade step
    always_comb
    begin
        cell_c0[0] = px_in[P_W-1:32];
        cell_c0[1] = py_in[P_W-1:32];
        cell_c0[2] = pz_in[P_W-1:32];
        t_c0[0] = fx_t'(px_in[31:32-FRAC_BITS]);
        t_c0[1] = fx_t'(py_in[31:32-FRAC_BITS]);
        t_c0[2] = fx_t'(pz_in[31:32-FRAC_BITS]);
        for (int d = 0; d < 3; d++)
        begin
            poly_c0[d] = fmul(t_c0[d], fx_t'(t_c0[d] * fx_t'(6)) - fx_t'(15) * ONE)
                + fx_t'(10) * ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_s1_reg <= cell_c0;
        t_s1_reg    <= t_c0;
        poly_s1_reg <= poly_c0;
        hi0_s1_reg  <= perm(cell_c0[0]);
        hi1_s1_reg  <= perm(cell_c0[0] + 8'd1);
    end

    // Second hash level; second fade step
    assign a_c1 = 9'(hi0_s1_reg) + 9'(cell_s1_reg[1]);
    assign b_c1 = 9'(hi1_s1_reg) + 9'(cell_s1_reg[1]);

    always_ff @(posedge clk)
    begin
        t_s2_reg   <= t_s1_reg;
        for (int d = 0; d < 3; d++)
        begin
            q_s2_reg[d] <= fmul(t_s1_reg[d], poly_s1_reg[d]);
        end
        hi0_s2_reg <= hi0_s1_reg;
        hi1_s2_reg <= hi1_s1_reg;
        a_s2_reg   <= a_c1[HASH_W-1:0];
        b_s2_reg   <= b_c1[HASH_W-1:0];
        aa_s2_reg  <= perm(a_c1[7:0]) + cell_s1_reg[2];
        ab_s2_reg  <= perm(a_c1[7:0] + 8'd1) + cell_s1_reg[2];
        ba_s2_reg  <= perm(b_c1[7:0]) + cell_s1_reg[2];
        bb_s2_reg  <= perm(b_c1[7:0] + 8'd1) + cell_s1_reg[2];
    end

    // Pick corner hashes for the dimension in use
    always_comb
    begin
        look_c2[0] = perm(aa_s2_reg);
        look_c2[1] = perm(ba_s2_reg);
        look_c2[2] = perm(ab_s2_reg);
        look_c2[3] = perm(bb_s2_reg);
        look_c2[4] = perm(aa_s2_reg + 8'd1);
        look_c2[5] = perm(ba_s2_reg + 8'd1);
        look_c2[6] = perm(ab_s2_reg + 8'd1);
        look_c2[7] = perm(bb_s2_reg + 8'd1);
        for (int k = 0; k < 8; k++)
        begin
            h_c2[k] = '0;
        end
        if (is_1d)
        begin
            h_c2[0] = hi0_s2_reg[HASH_W-1:0];
            h_c2[1] = hi1_s2_reg[HASH_W-1:0];
        end
        else if (is_2d)
        begin
            h_c2[0] = a_s2_reg;
            h_c2[1] = b_s2_reg;
            h_c2[2] = a_s2_reg + 4'd1;
            h_c2[3] = b_s2_reg + 4'd1;
        end
        else
        begin
            for (int k = 0; k < 8; k++)
            begin
                h_c2[k] = look_c2[k][HASH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_s3_reg <= h_c2;
        t_s3_reg <= t_s2_reg;
        for (int d = 0; d < 3; d++)
        begin
            r_s3_reg[d] <= fmul(t_s2_reg[d], q_s2_reg[d]);
        end
    end

    // Gradient dot products at the eight corners
    always_comb
    begin
        yy_c3 = is_1d ? fx_t'(0) : t_s3_reg[1];
        zz_c3 = (is_1d || is_2d) ? fx_t'(0) : t_s3_reg[2];
        for (int k = 0; k < 8; k++)
        begin
            g_c3[k] = grad(h_s3_reg[k],
                           k[0] ? t_s3_reg[0] - ONE : t_s3_reg[0],
                           k[1] ? t_s3_reg[1] - ONE : yy_c3,
                           k[2] ? t_s3_reg[2] - ONE : zz_c3);
        end
    end

    always_ff @(posedge clk)
    begin
        g_s4_reg <= g_c3;
        for (int d = 0; d < 3; d++)
        begin
            fade_s4_reg[d] <= fmul(t_s3_reg[d], r_s3_reg[d]);
        end
    end

    // Interpolate along x
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            p1_s5_reg[k] <= fade_s4_reg[0] * (g_s4_reg[2*k+1] - g_s4_reg[2*k]);
            b1_s5_reg[k] <= g_s4_reg[2*k];
        end
        fv_s5_reg <= fade_s4_reg[1];
        fw_s5_reg <= fade_s4_reg[2];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            l_s6_reg[k] <= b1_s5_reg[k] + fx_t'(p1_s5_reg[k] >>> FRAC_BITS);
        end
        fv_s6_reg <= fv_s5_reg;
        fw_s6_reg <= fw_s5_reg;
    end

    // Interpolate along y
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            p2_s7_reg[k] <= fv_s6_reg * (l_s6_reg[2*k+1] - l_s6_reg[2*k]);
            b2_s7_reg[k] <= l_s6_reg[2*k];
        end
        fw_s7_reg <= fw_s6_reg;
        l0_s7_reg <= l_s6_reg[0];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            m_s8_reg[k] <= b2_s7_reg[k] + fx_t'(p2_s7_reg[k] >>> FRAC_BITS);
        end
        fw_s8_reg <= fw_s7_reg;
        l0_s8_reg <= l0_s7_reg;
    end

    // Interpolate along z
    always_ff @(posedge clk)
    begin
        p3_s9_reg <= fw_s8_reg * (m_s8_reg[1] - m_s8_reg[0]);
        m0_s9_reg <= m_s8_reg[0];
        l0_s9_reg <= l0_s8_reg;
    end

    // Select the octave noise for the dimension in use
    always_comb
    begin
        priority if (is_1d)
        begin
            n_next = l0_s9_reg;
        end
        else if (is_2d)
        begin
            n_next = m0_s9_reg;
        end
        else
        begin
            n_next = m0_s9_reg + fx_t'(p3_s9_reg >>> FRAC_BITS);
        end
    end

    // Weight by amplitude and, for an active octave, add into the running sum
    assign sum_next = sum_in + (active ? SUM_W'(pa_s11_reg) : SUM_W'(0));

    always_ff @(posedge clk)
    begin
        n_s10_reg  <= n_next;
        pa_s11_reg <= n_s10_reg * $signed({1'b0, amp_in});
        sum_reg    <= sum_next;
    end

    // Hand the point on at double frequency
    always_ff @(posedge clk)
    begin
        px_reg <= {px_in[P_W-2:0], 1'b0};
        py_reg <= {py_in[P_W-2:0], 1'b0};
        pz_reg <= {pz_in[P_W-2:0], 1'b0};
    end

    // Advance the amplitude by persistence
    assign amp_prod = (2*AMP_W)'(amp_in) * (2*AMP_W)'(cfg.pers);
    assign amp_next = amp_prod[AMP_W+15:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= AMP_ONE;
        end
        else
        begin
            amp_reg <= amp_next;
        end
    end

    assign px_out  = px_reg;
    assign py_out  = py_reg;
    assign pz_out  = pz_reg;
    assign amp_out = amp_reg;
    assign sum_out = sum_reg;

endmodule

@@ src/fractal_gradient_noise_unit.sv @@
// done pulses when noise_value shows the result for a start that was taken.
// Throughput: one point per cycle; busy stays low, start may be high every cycle.
// Each octave is a cell of twelve pipeline stages; cells are staggered by a register.
// rst_n resets the config, amplitude and valid registers and empties the pipeline.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fractal_gradient_noise_unit #(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fgn_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [fgn_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [fgn_pkg::COORD_W-1:0]  coord_z,
    output logic                                done,
    output logic signed [fgn_pkg::OUT_W-1:0]    noise_value,
    input  logic                                cfg_write,
    input  logic [fgn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fgn_pkg::COORD_W-1:0]         cfg_data
);
    import fgn_pkg::*;

    localparam int SUM_W  = FRAC_BITS + 29;
    localparam int PIPE_N = MAX_OCTAVES + 13;

    logic [COORD_W-1:0] offset_x_reg;
    logic [COORD_W-1:0] offset_y_reg;
    logic [COORD_W-1:0] offset_z_reg;
    logic [BASE_W-1:0]  base_frequency_reg;
    logic [AMP_W-1:0]   persistence_reg;
    logic [3:0]         octave_count_reg;
    logic [1:0]         dimension_mode_reg;

    fgn_cfg_t           cfg;
    logic               accept;
    logic [PIPE_N-1:0]  valid_reg;
    logic [PIPE_N-1:0]  valid_next;
    logic               done_reg;

    logic [P_W-1:0]     px_c [MAX_OCTAVES+1];
    logic [P_W-1:0]     py_c [MAX_OCTAVES+1];
    logic [P_W-1:0]     pz_c [MAX_OCTAVES+1];
    logic [AMP_W-1:0]   amp_c [MAX_OCTAVES+1];
    logic signed [SUM_W-1:0] sum_c [MAX_OCTAVES+1];

    logic signed [SUM_W-1:0] shifted;
    logic signed [OUT_W-1:0] noise_reg;
    logic signed [OUT_W-1:0] noise_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
            offset_z_reg       <= '0;
            base_frequency_reg <= 24'd65536;
            persistence_reg    <= 17'd32768;
            octave_count_reg   <= 4'd1;
            dimension_mode_reg <= 2'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OFFSET_X:       offset_x_reg       <= cfg_data;
                REG_OFFSET_Y:       offset_y_reg       <= cfg_data;
                REG_OFFSET_Z:       offset_z_reg       <= cfg_data;
                REG_BASE_FREQUENCY: base_frequency_reg <= cfg_data[BASE_W-1:0];
                REG_PERSISTENCE:    persistence_reg    <= cfg_data[AMP_W-1:0];
                REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[3:0];
                REG_DIMENSION_MODE: dimension_mode_reg <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    // Clamp persistence and octave count
    always_comb
    begin
        cfg.mode = dimension_mode_reg;
        cfg.pers = (persistence_reg > AMP_ONE) ? AMP_ONE : persistence_reg;
        cfg.octs = (OCT_W'(octave_count_reg) > OCT_W'(MAX_OCTAVES))
            ? OCT_W'(MAX_OCTAVES) : OCT_W'(octave_count_reg);
    end

    fgn_front u_front (
        .clk            (clk),
        .accept         (accept),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .offset_x       (offset_x_reg),
        .offset_y       (offset_y_reg),
        .offset_z       (offset_z_reg),
        .base_frequency (base_frequency_reg),
        .px             (px_c[0]),
        .py             (py_c[0]),
        .pz             (pz_c[0])
    );

    assign amp_c[0] = AMP_ONE;
    assign sum_c[0] = '0;

    // One cell per octave
    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_cell
        fgn_cell #(
            .IDX       (o),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg),
            .px_in   (px_c[o]),
            .py_in   (py_c[o]),
            .pz_in   (pz_c[o]),
            .amp_in  (amp_c[o]),
            .sum_in  (sum_c[o]),
            .px_out  (px_c[o+1]),
            .py_out  (py_c[o+1]),
            .pz_out  (pz_c[o+1]),
            .amp_out (amp_c[o+1]),
            .sum_out (sum_c[o+1])
        );
    end

    // Drop fraction bits and saturate to the output range
    always_comb
    begin
        shifted = sum_c[MAX_OCTAVES] >>> FRAC_BITS;
        priority if (shifted > SUM_W'(1048575))
        begin
            noise_next = OUT_W'(1048575);
        end
        else if (shifted < -SUM_W'(1048576))
        begin
            noise_next = -OUT_W'(1048576) ;
        end
        else
        begin
            noise_next = OUT_W'(shifted);
        end
    end

    // Track transfers through the pipeline
    assign valid_next = {valid_reg[PIPE_N-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[PIPE_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
    end

    assign done        = done_reg;
    assign noise_value = noise_reg;

endmodule

@@ src/fgn_checker.sv @@
`include "fractal_gradient_noise_unit_defines.svh"

module fgn_checker #(
    parameter int MAX_OCTAVES = 8
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    localparam int LAT = MAX_OCTAVES + 14;

    // A transfer in always yields a result
    `FGN_ASSERT_IMPLY(a_result_follows, start && !busy, ##LAT done)
    // A result never appears without a transfer in
    `FGN_ASSERT_IMPLY(a_result_has_cause, done, $past(start && !busy, LAT))
    // The unit never refuses a point
    `FGN_ASSERT_NEVER(a_never_busy, busy)

endmodule

bind fractal_gradient_noise_unit fgn_checker #(
    .MAX_OCTAVES (MAX_OCTAVES)
) u_fgn_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

// Scoreboard: predicts fractal noise per accepted point, checks results in order
class noise_scoreboard;
    logic [31:0] off_x, off_y, off_z;
    logic [23:0] base_freq;
    logic [16:0] pers;
    logic [3:0]  octaves;
    logic [1:0]  mode;
    logic signed [20:0] pending_noise[$];
    int errors;

    function new();
        errors = 0;
        reset_regs();
    endfunction

    function void reset_regs();
        off_x = '0;
        off_y = '0;
        off_z = '0;
        base_freq = 24'd65536;
        pers = 17'd32768;
        octaves = 4'd1;
        mode = 2'd3;
    endfunction

    function void write_reg(fgn_pkg::cfg_reg_t idx, logic [31:0] data);
        case (idx)
            fgn_pkg::REG_OFFSET_X:       off_x = data;
            fgn_pkg::REG_OFFSET_Y:       off_y = data;
            fgn_pkg::REG_OFFSET_Z:       off_z = data;
            fgn_pkg::REG_BASE_FREQUENCY: base_freq = data[23:0];
            fgn_pkg::REG_PERSISTENCE:    pers = data[16:0];
            fgn_pkg::REG_OCTAVE_COUNT:   octaves = data[3:0];
            fgn_pkg::REG_DIMENSION_MODE: mode = data[1:0];
            default: ;
        endcase
    endfunction

    // Product shifted right by 16, rounded toward minus infinity
    function automatic longint fmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint fade(longint t);
        longint poly;
        poly = fmul(t, t * 6 - 15 * 65536) + 10 * 65536;
        return fmul(t, fmul(t, fmul(t, poly)));
    endfunction

    function automatic longint lerp(longint t, longint a, longint b);
        return a + fmul(t, b - a);
    endfunction

    function automatic int unsigned pt(int unsigned i);
        return fgn_pkg::PERM[i & 255];
    endfunction

    function automatic longint grad(int unsigned hash, longint x, longint y, longint z);
        int unsigned h;
        longint u, v;
        h = hash & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic longint lattice(int unsigned i, int unsigned j, int unsigned k,
                                       longint x, longint y, longint z);
        longint u, v, w, x1, y1, z1, n0, n1;
        int unsigned a, b, aa, ab, ba, bb;
        u = fade(x); v = fade(y); w = fade(z);
        x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
        a = pt(i) + j;
        b = pt(i + 1) + j;
        if (mode == fgn_pkg::DIM_1D)
            return lerp(u, grad(pt(i), x, 0, 0), grad(pt(i + 1), x1, 0, 0));
        // two-dimensional hash uses the first lookup directly
        if (mode == fgn_pkg::DIM_2D)
            return lerp(v, lerp(u, grad(a, x, y, 0), grad(b, x1, y, 0)),
                           lerp(u, grad(a + 1, x, y1, 0), grad(b + 1, x1, y1, 0)));
        aa = pt(a) + k; ab = pt(a + 1) + k;
        ba = pt(b) + k; bb = pt(b + 1) + k;
        n0 = lerp(v, lerp(u, grad(pt(aa), x, y, z), grad(pt(ba), x1, y, z)),
                     lerp(u, grad(pt(ab), x, y1, z), grad(pt(bb), x1, y1, z)));
        n1 = lerp(v, lerp(u, grad(pt(aa + 1), x, y, z1), grad(pt(ba + 1), x1, y, z1)),
                     lerp(u, grad(pt(ab + 1), x, y1, z1), grad(pt(bb + 1), x1, y1, z1)));
        return lerp(w, n0, n1);
    endfunction

    function automatic logic signed [20:0] fbm(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz);
        logic [63:0] px, py, pz, f, sx, sy, sz;
        longint acc, amp, p;
        int nocts;
        px = {{32{cx[31]}}, cx} + {{32{off_x[31]}}, off_x};
        py = {{32{cy[31]}}, cy} + {{32{off_y[31]}}, off_y};
        pz = {{32{cz[31]}}, cz} + {{32{off_z[31]}}, off_z};
        // wrap the translation at 32 bits
        px = {{32{px[31]}}, px[31:0]};
        py = {{32{py[31]}}, py[31:0]};
        pz = {{32{pz[31]}}, pz[31:0]};
        nocts = (octaves > 8) ? 8 : octaves;
        p = (pers > 17'd65536) ? 65536 : pers;
        amp = 65536;
        acc = 0;
        for (int o = 0; o < nocts; o++) begin
            f = {40'd0, base_freq} << o;
            sx = px * f; sy = py * f; sz = pz * f;
            acc += amp * lattice(sx[39:32], sy[39:32], sz[39:32],
                                 sx[31:16], sy[31:16], sz[31:16]);
            amp = (amp * p) >> 16;
        end
        acc = acc >>> 16;
        if (acc > 1048575) acc = 1048575;
        if (acc < -1048576) acc = -1048576;
        return acc[20:0];
    endfunction

    function void note_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        pending_noise.push_back(fbm(cx, cy, cz));
    endfunction

    function void check_noise(logic signed [20:0] got);
        logic signed [20:0] want;
        if (pending_noise.size() == 0) begin
            $error("noise_value: unexpected result %0d", got);
            errors++;
            return;
        end
        want = pending_noise.pop_front();
        if (got !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    import fgn_pkg::*;

    localparam int LATENCY = 8 + 14;

    logic clk, rst_n, start, busy, done, cfg_write;
    logic signed [31:0] coord_x, coord_y, coord_z;
    logic signed [20:0] noise_value;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    noise_scoreboard sb;
    int stall_cnt;

    fractal_gradient_noise_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .done(done), .noise_value(noise_value),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Check each result at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_noise(noise_value);
    end

    // Write one register while the block is idle
    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_write <= 1'b0;
    endtask

    // Present one point and hold until the transfer
    task automatic send_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        start   <= 1'b1;
        coord_x <= cx;
        coord_y <= cy;
        coord_z <= cz;
        do @(posedge clk); while (busy);
        sb.note_point(cx, cy, cz);
    endtask

    // Drop start and let a number of cycles pass
    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every outstanding result plus pipeline drain
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_noise.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_burst(int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && left > 0; b++) begin
                send_point($urandom, $urandom, $urandom);
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
    endtask

    // Random setting of every register
    task automatic random_regs();
        write_reg(REG_OFFSET_X, $urandom);
        write_reg(REG_OFFSET_Y, $urandom);
        write_reg(REG_OFFSET_Z, $urandom);
        write_reg(REG_BASE_FREQUENCY, ($urandom_range(0, 3) == 0) ? $urandom
                                       : $urandom_range(0, 32'h40000));
        write_reg(REG_PERSISTENCE, $urandom_range(0, 17'h1FFFF));
        write_reg(REG_OCTAVE_COUNT, $urandom_range(0, 15));
        write_reg(REG_DIMENSION_MODE, $urandom_range(0, 3));
    endtask

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'hFFFFFFFF, 32'h00000001, 32'hFFFF8000);
        send_point(32'h00018000, 32'hFFFE4000, 32'h0003C000);
        drain();

        // Maximum octaves, full persistence, offsets that wrap
        write_reg(REG_OFFSET_X, 32'h7FFFFFFF);
        write_reg(REG_OFFSET_Y, 32'h80000000);
        write_reg(REG_OFFSET_Z, 32'hFFFFFFFF);
        write_reg(REG_BASE_FREQUENCY, 24'hFFFFFF);
        write_reg(REG_PERSISTENCE, 17'd65536);
        write_reg(REG_OCTAVE_COUNT, 4'd8);
        write_reg(REG_DIMENSION_MODE, DIM_1D);
        send_point(32'h00000001, 32'h0, 32'h0);
        send_point(32'h7FFFFFFF, 32'h12345678, 32'h9ABCDEF0);
        drain();
        // two-dimensional hash
        write_reg(REG_DIMENSION_MODE, DIM_2D);
        send_point(32'h00010000, 32'h00FF8000, 32'h0);
        send_point(32'hDEADBEEF, 32'h0BADF00D, 32'h0);
        drain();

        // Persistence above one, octave count above maximum, mode zero
        write_reg(REG_PERSISTENCE, 17'h1FFFF);
        write_reg(REG_OCTAVE_COUNT, 4'd15);
        write_reg(REG_DIMENSION_MODE, 2'd0);
        write_reg(REG_BASE_FREQUENCY, 24'd0);
        send_point(32'h12340000, 32'h5678ABCD, 32'hFEDC1234);
        drain();
        write_reg(REG_BASE_FREQUENCY, 24'h800000);
        send_point(32'h0000FFFF, 32'hFFFF0001, 32'h80008000);
        drain();
        // zero octaves
        write_reg(REG_OCTAVE_COUNT, 4'd0);
        send_point(32'h11111111, 32'h22222222, 32'h33333333);
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            random_regs();
            random_burst(50);
            drain();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/fgn_pkg.sv
src/fgn_front.sv
src/fgn_cell.sv
src/fractal_gradient_noise_unit.sv
src/fgn_checker.sv
bench/testbench.sv
